// ===== sv/upq_pkg.sv =====
// Shared types for the unsorted priority queue: command and response payloads,
// the cell control bundle and the scan token that travels down the cell chain.
// No dependencies.
package upq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned TAG_W         = 16;
	localparam int unsigned PRIO_W        = 32;
	localparam int unsigned COUNT_W       = 5;

	typedef enum logic [1:0] {
		CMD_ENQUEUE  = 2'd0,
		CMD_DEQUEUE  = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_CLEAR    = 2'd3
	} upq_cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_HIGHER    = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} upq_status_t;

	typedef struct packed {
		upq_cmd_code_t            command;
		logic [TAG_W-1:0]         item_tag;
		logic signed [PRIO_W-1:0] new_priority;
	} upq_cmd_t;

	typedef struct packed {
		upq_status_t              status;
		logic [TAG_W-1:0]         removed_tag;
		logic [TAG_W-1:0]         head_tag;
		logic signed [PRIO_W-1:0] head_priority;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
	} upq_rsp_t;

	typedef struct packed {
		logic                     load;
		logic                     shift;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
	} upq_ctrl_t;

	typedef struct packed {
		logic                     vld;
		logic                     dec;
		logic [TAG_W-1:0]         key_tag;
		logic signed [PRIO_W-1:0] key_prio;
		logic                     found;
		logic                     lowered;
		logic                     any;
		logic [TAG_W-1:0]         best_tag;
		logic signed [PRIO_W-1:0] best_prio;
	} upq_tok_t;

endpackage

// ===== sv/upq_cell.sv =====
// One slot of the queue: holds a tag and a priority, loads, shifts from its upper
// neighbor, and updates the scan token that passes through it.
// Depends on upq_pkg.
module upq_cell #(
	parameter int unsigned DEPTH = upq_pkg::DEPTH_DEFAULT,
	parameter int unsigned IDX   = 0,
	localparam int unsigned CW   = $clog2(DEPTH + 1),
	localparam int unsigned IW   = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  upq_pkg::upq_ctrl_t                ctrl,
	input  logic [CW-1:0]                     count,
	input  logic [IW-1:0]                     shift_at,
	input  upq_pkg::upq_tok_t                 tok_in,
	input  logic [IW-1:0]                     idx_in,
	input  logic [upq_pkg::TAG_W-1:0]         next_tag,
	input  logic signed [upq_pkg::PRIO_W-1:0] next_prio,
	output upq_pkg::upq_tok_t                 tok_out,
	output logic [IW-1:0]                     idx_out,
	output logic [upq_pkg::TAG_W-1:0]         tag,
	output logic signed [upq_pkg::PRIO_W-1:0] prio
);
	import upq_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	logic [TAG_W-1:0]         tag_q;
	logic signed [PRIO_W-1:0] prio_q;
	upq_tok_t                 tok_q;
	logic [IW-1:0]            idx_q;

	logic                     occupied;
	logic                     hit;
	logic                     lower;
	logic                     upd;
	logic signed [PRIO_W-1:0] eff_prio;
	logic                     take;
	upq_tok_t                 tok_nxt;
	logic [IW-1:0]            idx_nxt;

	assign occupied = IDX_C < count;
	assign hit      = tok_in.vld && tok_in.dec && occupied && !tok_in.found
	                  && (tok_in.key_tag == tag_q);
	assign lower    = tok_in.key_prio < prio_q;
	assign upd      = hit && lower;
	assign eff_prio = upd ? tok_in.key_prio : prio_q;
	assign take     = occupied && (!tok_in.any || (eff_prio < tok_in.best_prio)
	                  || ((eff_prio == tok_in.best_prio) && (tag_q < tok_in.best_tag)));

	always_comb begin
		tok_nxt = tok_in;
		idx_nxt = idx_in;
		if (hit) begin
			tok_nxt.found   = 1'b1;
			tok_nxt.lowered = lower;
		end
		if (take) begin
			tok_nxt.any       = 1'b1;
			tok_nxt.best_tag  = tag_q;
			tok_nxt.best_prio = eff_prio;
			idx_nxt           = IDX_I;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_nxt;
		if (ctrl.load && (count == IDX_C)) begin
			tag_q  <= ctrl.tag;
			prio_q <= ctrl.prio;
		end else if (ctrl.shift && (IDX_I >= shift_at)) begin
			tag_q  <= next_tag;
			prio_q <= next_prio;
		end else if (upd) begin
			prio_q <= tok_in.key_prio;
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;
	assign tag     = tag_q;
	assign prio    = prio_q;

endmodule

// ===== sv/unsorted_priority_queue.sv =====
// Top level of the unsorted priority queue: command sequencer, response register
// and the chain of upq_cell slots. Depends on upq_pkg and upq_cell.
//
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_ready  upq_cmd_t: command, item_tag, new_priority
// rsp      out        rsp_valid / rsp_ready  upq_rsp_t: status, removed_tag, head_tag,
//                                            head_priority, entry_count, is_empty
//
// One command is in work at a time. A scan token walks the cell chain one cell per cycle.
// Enqueue, decrease, clear and a dequeue of an empty queue run a single scan; a dequeue
// of a non-empty queue runs a scan to find the minimum, a shift, then a second scan.
// cmd_ready returns at the edge that stages the response.
// Reset empties the queue; slot contents need no clearing.
// A stalled response holds in its register; the next command is taken once it is staged.
module unsorted_priority_queue #(
	parameter int unsigned DEPTH = upq_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  upq_pkg::upq_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output upq_pkg::upq_rsp_t rsp
);
	import upq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_WAIT,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                   state_q;
	upq_cmd_t                 cmd_q;
	logic [CW-1:0]            count_q;
	upq_status_t              status_q;
	logic [TAG_W-1:0]         removed_q;
	logic                     first_pass_q;
	logic [IW-1:0]            min_idx_q;
	upq_rsp_t                 res_q;
	upq_rsp_t                 rsp_q;
	logic                     rsp_valid_q;

	upq_ctrl_t                ctrl;
	upq_tok_t                 seed;
	upq_tok_t                 tok   [DEPTH];
	logic [IW-1:0]            idx   [DEPTH];
	logic [TAG_W-1:0]         tags  [DEPTH];
	logic signed [PRIO_W-1:0] prios [DEPTH];
	upq_tok_t                 last;
	logic                     accept;
	upq_status_t              final_status;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign last      = tok[DEPTH-1];

	always_comb begin
		ctrl.load  = accept && (cmd.command == CMD_ENQUEUE) && (count_q != FULL_C);
		ctrl.shift = (state_q == S_SHIFT);
		ctrl.tag   = cmd.item_tag;
		ctrl.prio  = cmd.new_priority;
	end

	always_comb begin
		seed          = '0;
		seed.vld      = (state_q == S_LAUNCH);
		seed.dec      = (cmd_q.command == CMD_DECREASE);
		seed.key_tag  = cmd_q.item_tag;
		seed.key_prio = cmd_q.new_priority;
	end

	always_comb begin
		final_status = status_q;
		if (cmd_q.command == CMD_DECREASE) begin
			if (count_q == '0) begin
				final_status = ST_EMPTY;
			end else if (!last.found) begin
				final_status = ST_NOT_FOUND;
			end else if (last.lowered) begin
				final_status = ST_OK;
			end else begin
				final_status = ST_HIGHER;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		upq_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.count     (count_q),
			.shift_at  (min_idx_q),
			.tok_in    ((i == 0) ? seed : tok[(i == 0) ? 0 : i - 1]),
			.idx_in    ((i == 0) ? '0 : idx[(i == 0) ? 0 : i - 1]),
			.next_tag  ((i == DEPTH - 1) ? '0 : tags[(i == DEPTH - 1) ? i : i + 1]),
			.next_prio ((i == DEPTH - 1) ? '0 : prios[(i == DEPTH - 1) ? i : i + 1]),
			.tok_out   (tok[i]),
			.idx_out   (idx[i]),
			.tag       (tags[i]),
			.prio      (prios[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			count_q      <= '0;
			status_q     <= ST_OK;
			removed_q    <= '0;
			first_pass_q <= 1'b0;
			min_idx_q    <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd;
						removed_q    <= '0;
						first_pass_q <= (cmd.command == CMD_DEQUEUE) && (count_q != '0);
						state_q      <= S_LAUNCH;
						unique case (cmd.command)
							CMD_ENQUEUE: begin
								if (count_q == FULL_C) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CW'(1);
								end
							end
							CMD_DEQUEUE: begin
								status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
							end
							CMD_DECREASE: begin
								status_q <= ST_OK;
							end
							CMD_CLEAR: begin
								status_q <= ST_OK;
								count_q  <= '0;
							end
						endcase
					end
				end
				S_LAUNCH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (last.vld) begin
						if (first_pass_q) begin
							first_pass_q <= 1'b0;
							removed_q    <= last.best_tag;
							min_idx_q    <= idx[DEPTH-1];
							state_q      <= S_SHIFT;
						end else begin
							res_q.status        <= final_status;
							res_q.removed_tag   <= removed_q;
							res_q.head_tag      <= last.any ? last.best_tag : '0;
							res_q.head_priority <= last.any ? last.best_prio : '0;
							res_q.entry_count   <= COUNT_W'(count_q);
							res_q.is_empty      <= (count_q == '0);
							state_q             <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					count_q <= count_q - CW'(1);
					state_q <= S_LAUNCH;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/upq_checker.sv =====
// Port-level checks for the unsorted priority queue, bound to the top level.
// Depends on upq_pkg and unsorted_priority_queue.
module upq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input upq_pkg::upq_cmd_t cmd,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input upq_pkg::upq_rsp_t rsp
);
	import upq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or dropped.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("Empty flag disagrees with entry count.");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> (rsp.head_tag == '0) && (rsp.head_priority == '0))
		else $error("Empty queue reports a head entry.");

	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.removed_tag != '0) |-> (rsp.status == ST_OK))
		else $error("Removed tag reported on a failed command.");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("Second command taken before the first completed.");

endmodule

bind unsorted_priority_queue upq_checker u_upq_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for unsorted_priority_queue: a queued command driver, a response
// monitor and a software copy of the queue that predicts every response in order.
// Depends on upq_pkg and the unsorted_priority_queue RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import upq_pkg::*;

	localparam int unsigned DEPTH      = DEPTH_DEFAULT;
	localparam int unsigned RAND_ITEMS = 1150;
	localparam int unsigned DRAIN_AT   = 500;
	localparam int unsigned STALL_AT   = 700;
	localparam int unsigned STALL_LEN  = 600;
	localparam int unsigned CYCLE_CAP  = 600000;

	typedef struct {
		upq_cmd_t body;
		bit       drain;
	} pending_cmd_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	upq_cmd_t cmd       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	upq_rsp_t rsp;

	pending_cmd_t pending_cmds[$];
	upq_rsp_t     expected_rsp[$];

	logic [TAG_W-1:0]         slot_tag[DEPTH];
	logic signed [PRIO_W-1:0] slot_prio[DEPTH];
	int unsigned              held;

	bit          failed;
	bit          offering;
	bit          src_burst;
	bit          dst_burst;
	int unsigned idle_left;
	int unsigned hold_left;
	int unsigned results_seen;
	int unsigned cycle_count;
	int unsigned item_count;

	unsorted_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #6 clk = ~clk;

	function automatic int unsigned min_slot();
		int unsigned best;
		best = 0;
		for (int unsigned i = 1; i < held; i++) begin
			if ($signed(slot_prio[i]) < $signed(slot_prio[best]) ||
			    (slot_prio[i] == slot_prio[best] && slot_tag[i] < slot_tag[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic upq_rsp_t apply_command(upq_cmd_t c);
		upq_rsp_t    r;
		int unsigned m;
		bit          hit;
		r        = '0;
		r.status = ST_OK;
		case (c.command)
			CMD_ENQUEUE: begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot_tag[held]  = c.item_tag;
					slot_prio[held] = c.new_priority;
					held++;
				end
			end
			CMD_DEQUEUE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					m             = min_slot();
					r.removed_tag = slot_tag[m];
					for (int unsigned i = m; i + 1 < held; i++) begin
						slot_tag[i]  = slot_tag[i + 1];
						slot_prio[i] = slot_prio[i + 1];
					end
					held--;
				end
			end
			CMD_DECREASE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_NOT_FOUND;
					hit      = 1'b0;
					for (int unsigned i = 0; i < held && !hit; i++) begin
						if (slot_tag[i] == c.item_tag) begin
							hit = 1'b1;
							if ($signed(c.new_priority) < $signed(slot_prio[i])) begin
								slot_prio[i] = c.new_priority;
								r.status     = ST_OK;
							end else begin
								r.status = ST_HIGHER;
							end
						end
					end
				end
			end
			default: held = 0;
		endcase
		if (held == 0) begin
			r.is_empty = 1'b1;
		end else begin
			m               = min_slot();
			r.head_tag      = slot_tag[m];
			r.head_priority = slot_prio[m];
		end
		r.entry_count = COUNT_W'(held);
		return r;
	endfunction

	task automatic compare_response(upq_rsp_t got);
		upq_rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("response with no command outstanding: status %0d", got.status);
			failed = 1'b1;
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failed = 1'b1;
			end
			if (got.removed_tag !== want.removed_tag) begin
				$error("removed_tag: expected %0d, got %0d", want.removed_tag, got.removed_tag);
				failed = 1'b1;
			end
			if (got.head_tag !== want.head_tag) begin
				$error("head_tag: expected %0d, got %0d", want.head_tag, got.head_tag);
				failed = 1'b1;
			end
			if (got.head_priority !== want.head_priority) begin
				$error("head_priority: expected %0d, got %0d",
				       want.head_priority, got.head_priority);
				failed = 1'b1;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
				failed = 1'b1;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				failed = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
			offering  = 1'b0;
			idle_left = 0;
		end else begin
			offering = cmd_valid;
			if (cmd_valid && cmd_ready) begin
				expected_rsp.push_back(apply_command(cmd));
				offering = 1'b0;
				if ($urandom_range(0, 99) < 3)
					src_burst = ~src_burst;
				idle_left = src_burst ? 0 : $urandom_range(0, 18);
			end
			if (!offering) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_cmds.size() != 0 &&
				             !(pending_cmds[0].drain && expected_rsp.size() != 0)) begin
					cmd      <= pending_cmds[0].body;
					void'(pending_cmds.pop_front());
					offering = 1'b1;
				end
			end
			cmd_valid <= offering;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				compare_response(rsp);
				results_seen++;
				if ($urandom_range(0, 99) < 3)
					dst_burst = ~dst_burst;
				hold_left = dst_burst ? 0 : $urandom_range(0, 18);
				if (results_seen == STALL_AT)
					hold_left = STALL_LEN;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_ready <= (hold_left == 0);
		end
	end

	task automatic queue_cmd(upq_cmd_code_t op, logic [TAG_W-1:0] tag,
	                         logic [PRIO_W-1:0] pri, bit drain);
		pending_cmd_t p;
		p.body.command      = op;
		p.body.item_tag     = tag;
		p.body.new_priority = pri;
		p.drain             = drain;
		pending_cmds.push_back(p);
	endtask

	function automatic logic [TAG_W-1:0] pick_tag();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return TAG_W'($urandom_range(0, 7));
		else if (roll < 75)
			return (roll < 70) ? 16'hFFFF : 16'h0000;
		return TAG_W'($urandom);
	endfunction

	function automatic logic [PRIO_W-1:0] pick_priority();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return PRIO_W'($signed($urandom_range(0, 8)) - 4);
		else if (roll < 80)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic build_stimulus();
		int unsigned   phase_left;
		int unsigned   mode;
		int unsigned   roll;
		upq_cmd_code_t op;
		queue_cmd(CMD_DEQUEUE, 16'h0000, 32'h0000_0000, 1'b0);
		queue_cmd(CMD_DECREASE, 16'h0000, 32'h8000_0000, 1'b0);
		queue_cmd(CMD_ENQUEUE, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
		queue_cmd(CMD_ENQUEUE, 16'h0000, 32'h8000_0000, 1'b0);
		queue_cmd(CMD_ENQUEUE, 16'h0005, 32'h8000_0000, 1'b0);
		queue_cmd(CMD_DECREASE, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
		queue_cmd(CMD_DECREASE, 16'h1234, 32'h0000_0000, 1'b0);
		queue_cmd(CMD_DECREASE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		for (int unsigned i = 0; i < DEPTH - 3; i++)
			queue_cmd(CMD_ENQUEUE, TAG_W'(16'h8000 | (i * 16'h1111)), $urandom, 1'b0);
		queue_cmd(CMD_ENQUEUE, 16'h00AA, 32'h0000_0001, 1'b0);
		queue_cmd(CMD_DEQUEUE, 16'h0000, 32'h0000_0000, 1'b0);
		queue_cmd(CMD_CLEAR, 16'h0000, 32'h0000_0000, 1'b0);

		phase_left = 0;
		mode       = 0;
		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				mode       = $urandom_range(0, 2);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = CMD_CLEAR;
			else if (roll < ((mode == 0) ? 62 : (mode == 1) ? 22 : 40))
				op = CMD_ENQUEUE;
			else if (roll < ((mode == 0) ? 77 : (mode == 1) ? 77 : 70))
				op = CMD_DEQUEUE;
			else
				op = CMD_DECREASE;
			queue_cmd(op, pick_tag(), pick_priority(), n == DRAIN_AT);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		build_stimulus();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_cmds.size() != 0 || cmd_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 20) @(posedge clk);
		if (!failed && expected_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
